[sv/loop_transport_tick_advance_macros.svh]
// ----------------------------------------------------------------------------
// Transport tick counter assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef LOOP_TRANSPORT_TICK_ADVANCE_MACROS_SVH
`define LOOP_TRANSPORT_TICK_ADVANCE_MACROS_SVH

// same-cycle implication
`define LTTA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LTTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ltta_pkg.sv]
// ----------------------------------------------------------------------------
// Transport tick counter package
// Types, codes and widths shared by the tick counter and its serial units.
// ----------------------------------------------------------------------------
`default_nettype none

package ltta_pkg;

   localparam int TICK_W    = 31;
   localparam int MUL_A_W   = 42;
   localparam int MUL_B_W   = 16;
   localparam int PROD_W    = 58;
   localparam int DIV_W     = 44;
   localparam int DVS_W     = 31;
   localparam int DIV_CNT_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [TICK_W-1:0] TICK_MAX  = 31'h7FFF_FFFF;
   localparam logic [25:0]       TEMPO_ONE = 26'd65536;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PPQ        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEMPO      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SRATE      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_EN    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_START = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_END   = 3'd5;

   typedef enum logic [2:0] {
      FN_ADVANCE  = 3'd0,
      FN_PLAY     = 3'd1,
      FN_STOP     = 3'd2,
      FN_PAUSE    = 3'd3,
      FN_TOGGLE   = 3'd4,
      FN_SET_TICK = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      PS_STOPPED = 2'd0,
      PS_PLAYING = 2'd1,
      PS_PAUSED  = 2'd2
   } play_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_DIV,
      ST_FIX,
      ST_MOD,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_stat_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_stat_type;

endpackage

`default_nettype wire

[sv/loop_transport_tick_advance.sv]
// ----------------------------------------------------------------------------
// Musical transport tick counter with loop region
// Usage notes for the command stream, result stream and register port below.
// ----------------------------------------------------------------------------
// Commands arrive on the req_ stream (one transfer per command, code in tuser)
// and each one gives exactly one result transfer on the rsp_ stream.
// Registers are to be written through csr_ only while the block is idle; the
// block itself does not enforce this. A command without motion goes from the
// idle state to the done state, then into the result register; the next command
// can transfer once the block is back in idle. An advance with motion runs a
// serial multiplier over block_frames up to its highest set bit, then over
// ticks_per_quarter the same way (one bit per cycle), then the 44-step serial
// divider for the rounded tick delta; a loop wrap runs the divider once more.
// One command is in flight at a time.
// Reset: registers take their defaults, the transport is stopped at tick 0.
// Stall: a result waiting on rsp_tready holds; the next command is still taken
// and runs, and its result waits until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "loop_transport_tick_advance_macros.svh"

module loop_transport_tick_advance (
   input  logic                                  clock,
   input  logic                                  reset,
   // command stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [47:0]                           req_tdata,  // block_frames[15:0], new_tick[46:16]
   input  logic [2:0]                            req_tuser,  // func[2:0]
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [71:0]                           rsp_tdata,  // play_state[1:0], start_tick[32:2],
                                                             // end_tick[63:33], loop_wrapped[64]
   // register port
   input  logic                                  csr_wen,
   input  logic [ltta_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [ltta_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ltta_pkg::*;

   // configuration registers
   logic [15:0]       ppq_ff;
   logic [25:0]       tempo_ff;
   logic [18:0]       srate_ff;
   logic              loop_en_ff;
   logic [TICK_W-1:0] loop_start_ff;
   logic [TICK_W-1:0] loop_end_ff;

   // transport state
   ctrl_state_type    state_ff, state_in;
   play_state_type    play_ff, play_in;
   logic [TICK_W-1:0] pos_ff, pos_in;

   // per-command working registers
   func_type          func_ff;
   logic [TICK_W-1:0] new_tick_ff;
   logic              motion_ff;
   logic              loop_ok_ff;
   logic [TICK_W-1:0] len_ff;
   logic [TICK_W-1:0] start_ff;
   logic [DIV_W-1:0]  sum_ff;
   logic [TICK_W-1:0] end_ff;
   logic              wrap_ff;

   // output register
   logic              rsp_tvalid_ff;
   logic [71:0]       rsp_data_ff;

   // serial units
   mul_req_type       mul_req;
   mul_stat_type      mul_stat;
   div_req_type       div_req;
   div_stat_type      div_stat;

   logic              req_fire;
   logic              out_free;
   logic              commit;
   func_type          req_func;
   logic [15:0]       req_frames;
   logic [TICK_W-1:0] req_new_tick;
   logic              loop_ok_now;
   logic              motion_now;
   logic [25:0]       tempo_eff;
   logic [15:0]       ppq_eff;
   logic [24:0]       den_base;
   logic [PROD_W:0]   round_sum;
   logic [DIV_W-1:0]  sum_now;
   logic              wrap_now;
   logic [DIV_W-1:0]  mod_dividend;
   logic [TICK_W-1:0] sat_end;
   logic [TICK_W-1:0] res_start;
   logic              res_wrap;

   // ---------------------------------------------------------------- decode
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_func     = func_type'(req_tuser);
   assign req_frames   = req_tdata[15:0];
   assign req_new_tick = req_tdata[46:16];
   assign out_free     = !rsp_tvalid_ff || rsp_tready;
   assign commit       = (state_ff == ST_DONE) && out_free;

   assign loop_ok_now = loop_en_ff && (loop_end_ff > loop_start_ff);
   // motion needs playing, a nonempty block and a nonzero sample rate
   assign motion_now  = (req_func == FN_ADVANCE) && (play_ff == PS_PLAYING) &&
                        (req_frames != '0) && (srate_ff != '0);

   // clamp tempo to 1.0 bpm and ppq to 1
   assign tempo_eff = (tempo_ff < TEMPO_ONE) ? TEMPO_ONE : tempo_ff;
   assign ppq_eff   = (ppq_ff == '0) ? 16'd1 : ppq_ff;

   // 60 * sample_rate as 64x - 4x; full divisor is this times 2^16
   assign den_base = ({6'd0, srate_ff} << 6) - ({6'd0, srate_ff} << 2);

   // round half up: add half the divisor, drop the 2^16 factor, divide by den_base
   assign round_sum = {1'b0, mul_stat.product} + {19'd0, den_base, 15'd0};

   assign sum_now      = {{(DIV_W-TICK_W){1'b0}}, start_ff} + div_stat.quotient;
   assign wrap_now     = loop_ok_ff && (sum_ff >= {{(DIV_W-TICK_W){1'b0}}, loop_end_ff});
   assign mod_dividend = sum_ff - {{(DIV_W-TICK_W){1'b0}}, loop_start_ff};
   assign sat_end      = (sum_ff > {{(DIV_W-TICK_W){1'b0}}, TICK_MAX}) ?
                         TICK_MAX : sum_ff[TICK_W-1:0];

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = motion_now ? ST_MUL1 : ST_DONE;
            end
         end
         ST_MUL1: begin
            if (mul_stat.done) begin
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_stat.done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = wrap_now ? ST_MOD : ST_DONE;
         end
         ST_MOD: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- unit requests
   always_comb begin
      mul_req = '0;
      div_req = '0;
      case (state_ff)
         ST_IDLE: begin
            // frames * tempo first
            mul_req.start  = req_fire && motion_now;
            mul_req.mcand  = {{(MUL_A_W-26){1'b0}}, tempo_eff};
            mul_req.mplier = req_frames;
         end
         ST_MUL1: begin
            // then times ticks per quarter
            mul_req.start  = mul_stat.done;
            mul_req.mcand  = mul_stat.product[MUL_A_W-1:0];
            mul_req.mplier = ppq_eff;
         end
         ST_MUL2: begin
            div_req.start    = mul_stat.done;
            div_req.dividend = {1'b0, round_sum[PROD_W:16]};
            div_req.divisor  = {{(DVS_W-25){1'b0}}, den_base};
         end
         ST_FIX: begin
            // at or past loop end: take the offset modulo the loop length
            div_req.start    = wrap_now;
            div_req.dividend = mod_dividend;
            div_req.divisor  = len_ff;
         end
         default: begin
            mul_req = '0;
            div_req = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      play_in   = play_ff;
      pos_in    = pos_ff;
      res_start = pos_ff;
      res_wrap  = 1'b0;
      case (func_ff)
         FN_ADVANCE: begin
            if (motion_ff) begin
               pos_in    = end_ff;
               res_start = start_ff;
               res_wrap  = wrap_ff;
            end
         end
         FN_PLAY: begin
            play_in = PS_PLAYING;
         end
         FN_STOP: begin
            play_in = PS_STOPPED;
            pos_in  = '0;
         end
         FN_PAUSE: begin
            play_in = PS_PAUSED;
         end
         FN_TOGGLE: begin
            play_in = (play_ff == PS_PLAYING) ? PS_PAUSED : PS_PLAYING;
         end
         FN_SET_TICK: begin
            pos_in = new_tick_ff;
         end
         default: begin
            // unused codes: report, change nothing
            play_in = play_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ppq_ff        <= 16'd960;
         tempo_ff      <= 26'd7864320;
         srate_ff      <= 19'd48000;
         loop_en_ff    <= 1'b0;
         loop_start_ff <= '0;
         loop_end_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_PPQ:        ppq_ff        <= csr_wdata[15:0];
            CSR_TEMPO:      tempo_ff      <= csr_wdata[25:0];
            CSR_SRATE:      srate_ff      <= csr_wdata[18:0];
            CSR_LOOP_EN:    loop_en_ff    <= csr_wdata[0];
            CSR_LOOP_START: loop_start_ff <= csr_wdata[TICK_W-1:0];
            CSR_LOOP_END:   loop_end_ff   <= csr_wdata[TICK_W-1:0];
            default:        loop_en_ff    <= loop_en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         play_ff       <= PS_STOPPED;
         pos_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            play_ff       <= play_in;
            pos_ff        <= pos_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff     <= req_func;
         new_tick_ff <= req_new_tick;
         motion_ff   <= motion_now;
         loop_ok_ff  <= loop_ok_now;
         len_ff      <= loop_end_ff - loop_start_ff;
         // jump to loop start when already at or past loop end
         start_ff    <= (loop_ok_now && (pos_ff >= loop_end_ff)) ? loop_start_ff : pos_ff;
      end
      if ((state_ff == ST_DIV) && div_stat.done) begin
         sum_ff <= sum_now;
      end
      if (state_ff == ST_FIX) begin
         wrap_ff <= wrap_now;
         end_ff  <= sat_end;
      end
      if ((state_ff == ST_MOD) && div_stat.done) begin
         end_ff <= loop_start_ff + div_stat.remainder;
      end
      if (commit) begin
         rsp_data_ff <= {7'd0, res_wrap, pos_in, res_start, play_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- units
   ltta_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_stat (mul_stat)
   );

   ltta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat)
   );

   // ---------------------------------------------------------------- assertions
   `LTTA_ASSERT_NEXT(a_done_loads_rsp, commit, rsp_tvalid_ff, "result not presented after commit")
   `LTTA_ASSERT_NOW(a_mul_done_state, mul_stat.done, (state_ff == ST_MUL1) || (state_ff == ST_MUL2), "multiplier finished outside a multiply step")
   `LTTA_ASSERT_NOW(a_div_done_state, div_stat.done, (state_ff == ST_DIV) || (state_ff == ST_MOD), "divider finished outside a divide step")
   `LTTA_ASSERT_NOW(a_mod_in_loop, (state_ff == ST_MOD) && div_stat.done, div_stat.remainder < len_ff, "wrap remainder not below loop length")

endmodule

`default_nettype wire

[sv/ltta_mul.sv]
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// One multiplier bit per cycle, LSB first; stops once the remaining bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ltta_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  ltta_pkg::mul_req_type mul_req,
   output ltta_pkg::mul_stat_type mul_stat
);
   import ltta_pkg::*;

   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  mcand_ff, mcand_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (mul_req.start) begin
         acc_in    = '0;
         mcand_in  = {{(PROD_W-MUL_A_W){1'b0}}, mul_req.mcand};
         mplier_in = mul_req.mplier;
         run_in    = 1'b1;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         if (mplier_in == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign mul_stat.done    = done_ff;
   assign mul_stat.product = acc_ff;

endmodule

`default_nettype wire

[sv/ltta_div.sv]
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle over the full dividend width; gives quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ltta_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ltta_pkg::div_req_type div_req,
   output ltta_pkg::div_stat_type div_stat
);
   import ltta_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign div_stat.done      = done_ff;
   assign div_stat.quotient  = quo_ff;
   assign div_stat.remainder = rem_ff;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transport tick counter testbench
// Streams transport commands into the tick counter, bursty on the command
// side and stalling on the result side. A local model of the transport
// predicts each result. Register settings change between phases, only once
// the block has drained.
// ----------------------------------------------------------------------------

module tb_top;
   import ltta_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int PHASE_ITEMS  = 70;
   localparam int DRAIN_CYCLES = 160;

   // command codes the block decodes as no-ops
   localparam logic [2:0] FN_RSVD6 = 3'd6;
   localparam logic [2:0] FN_RSVD7 = 3'd7;

   typedef enum int {
      RDY_ALWAYS,
      RDY_MOSTLY,
      RDY_HALF,
      RDY_RUNS
   } ready_mode_type;

   typedef struct {
      logic [2:0]  func;
      logic [15:0] frames;
      logic [30:0] new_tick;
      bit          drain_first;   // hold this command until all results are back
   } tick_command_type;

   typedef struct {
      logic [1:0]  play_state;
      logic [30:0] start_tick;
      logic [30:0] end_tick;
      logic        loop_wrapped;
   } tick_report_type;

   // -------------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata  = '0;   // block_frames[15:0], new_tick[46:16]
   logic [2:0]            req_tuser  = '0;   // func[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [71:0]           rsp_tdata;         // play_state[1:0], start_tick[32:2],
                                             // end_tick[63:33], loop_wrapped[64]
   logic                  csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   loop_transport_tick_advance dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // -------------------------------------------------------------------------
   // Transport model: register mirror plus play state and tick
   // -------------------------------------------------------------------------
   logic [15:0]    cfg_ppq        = 16'd960;
   logic [25:0]    cfg_tempo      = 26'd7864320;
   logic [18:0]    cfg_srate      = 19'd48000;
   logic           cfg_loop_en    = 1'b0;
   logic [30:0]    cfg_loop_start = '0;
   logic [30:0]    cfg_loop_end   = '0;
   play_state_type xport_state    = PS_STOPPED;
   logic [30:0]    xport_tick     = '0;

   // Apply one command to the model and return the report it should produce.
   function automatic tick_report_type advance_transport(logic [2:0]  func,
                                                         logic [15:0] frames,
                                                         logic [30:0] new_tick);
      tick_report_type rpt;
      logic [63:0]     ppq, tempo, num, den, delta, pos, end_pos, span;
      logic            loop_ok;
      rpt.start_tick   = xport_tick;
      rpt.loop_wrapped = 1'b0;
      case (func)
         FN_ADVANCE: begin
            // motion only while playing, with frames and a nonzero rate
            if (xport_state == PS_PLAYING && frames != 0 && cfg_srate != 0) begin
               ppq   = (cfg_ppq == 0) ? 64'd1 : 64'(cfg_ppq);
               tempo = (cfg_tempo < TEMPO_ONE) ? 64'(TEMPO_ONE) : 64'(cfg_tempo);
               num   = 64'(frames) * tempo * ppq;
               den   = 64'd60 * 64'(cfg_srate) * 64'd65536;
               // round half up
               delta = (2 * num + den) / (2 * den);
               loop_ok = cfg_loop_en && (cfg_loop_end > cfg_loop_start);
               pos = 64'(xport_tick);
               // jump back first when the block starts at or past the loop end
               if (loop_ok && pos >= 64'(cfg_loop_end)) begin
                  pos            = 64'(cfg_loop_start);
                  rpt.start_tick = cfg_loop_start;
               end
               end_pos = pos + delta;
               if (loop_ok) begin
                  if (end_pos >= 64'(cfg_loop_end)) begin
                     span    = 64'(cfg_loop_end) - 64'(cfg_loop_start);
                     end_pos = 64'(cfg_loop_start) + (end_pos - 64'(cfg_loop_start)) % span;
                     rpt.loop_wrapped = 1'b1;
                  end
               end else if (end_pos > 64'(TICK_MAX)) begin
                  end_pos = 64'(TICK_MAX);
               end
               xport_tick = end_pos[30:0];
            end
         end
         FN_PLAY:     xport_state = PS_PLAYING;
         FN_STOP: begin
            xport_state = PS_STOPPED;
            xport_tick  = '0;
         end
         FN_PAUSE:    xport_state = PS_PAUSED;
         FN_TOGGLE:   xport_state = (xport_state == PS_PLAYING) ? PS_PAUSED : PS_PLAYING;
         FN_SET_TICK: xport_tick = new_tick;
         default: ;
      endcase
      rpt.play_state = xport_state;
      rpt.end_tick   = xport_tick;
      return rpt;
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard: predict on each command transfer, check each result transfer
   // -------------------------------------------------------------------------
   tick_report_type tick_reports_due[$];
   int              reports_checked = 0;
   int              mismatch_count  = 0;

   task automatic check_field(string name, logic [30:0] want, logic [30:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : score_proc
      tick_report_type due;
      if (!reset) begin
         // check results first, then book the command taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (tick_reports_due.size() == 0) begin
               $error("result transfer with no command outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               due = tick_reports_due.pop_front();
               check_field("play_state", 31'(due.play_state), 31'(rsp_tdata[1:0]));
               check_field("start_tick", due.start_tick, rsp_tdata[32:2]);
               check_field("end_tick", due.end_tick, rsp_tdata[63:33]);
               check_field("loop_wrapped", 31'(due.loop_wrapped), 31'(rsp_tdata[64]));
               reports_checked++;
            end
         end
         if (req_tvalid && req_tready)
            tick_reports_due.push_back(advance_transport(req_tuser, req_tdata[15:0],
                                                         req_tdata[46:16]));
      end
   end

   // -------------------------------------------------------------------------
   // Command driver: bursts of transfers with random gaps between them
   // -------------------------------------------------------------------------
   tick_command_type pending_cmds[$];
   int               commands_queued = 0;
   int               burst_left      = 0;
   int               gap_left        = 0;

   always @(posedge clock) begin : drive_proc
      tick_command_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         // the slot is free: either nothing was offered or it just transferred
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() == 0 ||
                      (pending_cmds[0].drain_first &&
                       (req_tvalid || tick_reports_due.size() != 0))) begin
            // nothing to send, or hold until every result is back
            req_tvalid <= 1'b0;
         end else begin
            cmd = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= cmd.func;
            req_tdata  <= {1'b0, cmd.new_tick, cmd.frames};
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // end of burst: pick the next burst and the gap before it,
               // now and then long enough to span a whole advance
               burst_left = $urandom_range(0, 30);
               gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 150)
                                                        : $urandom_range(0, 12);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result receiver: stall pattern switches between random modes
   // -------------------------------------------------------------------------
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left  = 0;
   int             run_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RDY_HALF:   rsp_tready <= ($urandom_range(0, 1) != 0);
            default: begin
               // long stalls broken by short ready windows
               if (run_left > 0) begin
                  run_left--;
               end else begin
                  rsp_tready <= !rsp_tready;
                  run_left = rsp_tready ? $urandom_range(1, 40) : $urandom_range(1, 6);
               end
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Cycle limit
   // -------------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_cmd(logic [2:0] func, logic [15:0] frames, logic [30:0] new_tick,
                            bit drain_first = 1'b0);
      tick_command_type cmd;
      cmd.func        = func;
      cmd.frames      = frames;
      cmd.new_tick    = new_tick;
      cmd.drain_first = drain_first;
      pending_cmds.push_back(cmd);
      commands_queued++;
   endtask

   // Block until every queued command has come back, then let the block settle.
   task automatic wait_quiet();
      while (reports_checked != commands_queued)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
   endtask

   // Drain, then write all six registers and mirror them into the model.
   task automatic load_setup(logic [15:0] ppq, logic [25:0] tempo, logic [18:0] srate,
                             logic loop_en, logic [30:0] loop_start, logic [30:0] loop_end);
      wait_quiet();
      write_reg(CSR_PPQ, 31'(ppq));
      write_reg(CSR_TEMPO, 31'(tempo));
      write_reg(CSR_SRATE, 31'(srate));
      write_reg(CSR_LOOP_EN, 31'(loop_en));
      write_reg(CSR_LOOP_START, loop_start);
      write_reg(CSR_LOOP_END, loop_end);
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_ppq        = ppq;
      cfg_tempo      = tempo;
      cfg_srate      = srate;
      cfg_loop_en    = loop_en;
      cfg_loop_start = loop_start;
      cfg_loop_end   = loop_end;
      @(posedge clock);
   endtask

   // Mostly advances with a steady supply of play; set tick aims at the loop
   // edges and the top of the range so jumps, wraps and saturation all occur.
   task automatic queue_random(int count);
      tick_command_type cmd;
      int               pick;
      for (int i = 0; i < count; i++) begin
         cmd.func        = FN_ADVANCE;
         cmd.frames      = 16'($urandom);
         cmd.new_tick    = 31'($urandom);
         cmd.drain_first = (i == 0) || ($urandom_range(0, 59) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            case ($urandom_range(0, 9))
               0:                cmd.frames = '0;
               1, 2, 3, 4, 5, 6: cmd.frames = 16'($urandom_range(1, 1024));
               7, 8:             cmd.frames = 16'($urandom_range(1, 8192));
               default: ;
            endcase
         end else if (pick < 65) begin
            cmd.func = FN_PLAY;
         end else if (pick < 70) begin
            cmd.func = FN_TOGGLE;
         end else if (pick < 74) begin
            cmd.func = FN_PAUSE;
         end else if (pick < 77) begin
            cmd.func = FN_STOP;
         end else if (pick < 95) begin
            cmd.func = FN_SET_TICK;
            case ($urandom_range(0, 4))
               0: ;
               1: cmd.new_tick = cfg_loop_start + 31'($urandom_range(0, 200));
               2: cmd.new_tick = cfg_loop_end - 31'($urandom_range(0, 100));
               3: cmd.new_tick = cfg_loop_end + 31'($urandom_range(0, 100));
               default: cmd.new_tick = TICK_MAX - 31'($urandom_range(0, 3000));
            endcase
         end else begin
            cmd.func = ($urandom_range(0, 1) != 0) ? FN_RSVD6 : FN_RSVD7;
         end
         queue_cmd(cmd.func, cmd.frames, cmd.new_tick, cmd.drain_first);
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus_proc
      logic [30:0] rnd_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pass on reset registers (960 ppq, 120 bpm, 48 kHz)
      queue_cmd(FN_ADVANCE, 16'd512, 31'd0);          // stopped: no motion
      queue_cmd(FN_PLAY, 16'hFFFF, TICK_MAX);
      queue_cmd(FN_ADVANCE, 16'd512, 31'd0);
      queue_cmd(FN_ADVANCE, 16'd0, 31'd0);            // zero frames: no motion
      queue_cmd(FN_ADVANCE, 16'hFFFF, 31'd0);
      queue_cmd(FN_PAUSE, 16'd0, 31'd0);
      queue_cmd(FN_ADVANCE, 16'd100, 31'd0);          // paused: no motion
      queue_cmd(FN_TOGGLE, 16'd0, 31'd0);             // paused to playing
      queue_cmd(FN_TOGGLE, 16'd0, 31'd0);             // playing to paused
      queue_cmd(FN_STOP, 16'd0, 31'd0);               // also zeroes the tick
      queue_cmd(FN_ADVANCE, 16'd700, 31'd0);
      queue_cmd(FN_TOGGLE, 16'd0, 31'd0);             // stopped to playing
      queue_cmd(FN_SET_TICK, 16'd0, TICK_MAX - 31'd5);
      queue_cmd(FN_ADVANCE, 16'd1000, 31'd0);         // saturate at the top
      queue_cmd(FN_ADVANCE, 16'hFFFF, 31'd0);
      queue_cmd(FN_RSVD6, 16'hFFFF, TICK_MAX);
      queue_cmd(FN_RSVD7, 16'h0000, 31'd0);
      queue_cmd(FN_SET_TICK, 16'd0, 31'd0);
      queue_cmd(FN_ADVANCE, 16'd12, 31'd0);           // 0.48 rounds down
      queue_cmd(FN_ADVANCE, 16'd13, 31'd0);           // 0.52 rounds up
      queue_cmd(FN_STOP, 16'd0, 31'd0);

      // 1 bpm, 1 ppq, 1 Hz: frames / 60, so 30 frames hits an exact half
      load_setup(16'd1, TEMPO_ONE, 19'd1, 1'b0, 31'd0, 31'd0);
      queue_cmd(FN_PLAY, 16'd0, 31'd0);
      queue_cmd(FN_ADVANCE, 16'd29, 31'd0);
      queue_cmd(FN_ADVANCE, 16'd30, 31'd0);
      queue_cmd(FN_ADVANCE, 16'd90, 31'd0);
      queue_random(PHASE_ITEMS);

      // fastest motion: large deltas drive the tick to saturation
      load_setup(16'hFFFF, 26'd65470464, 19'd1, 1'b0, 31'd0, 31'd0);
      queue_random(PHASE_ITEMS);

      // slowest motion: deltas round to zero
      load_setup(16'd1, TEMPO_ONE, 19'd384000, 1'b0, 31'd0, 31'd0);
      queue_random(PHASE_ITEMS);

      // ordinary loop region
      load_setup(16'd960, 26'd7864320, 19'd48000, 1'b1, 31'd1000, 31'd20000);
      queue_random(PHASE_ITEMS);

      // one-tick loop: any nonzero delta wraps back to the start
      load_setup(16'd480, 26'd9830400, 19'd44100, 1'b1, 31'd0, 31'd1);
      queue_random(PHASE_ITEMS);

      // loop pinned to the top of the tick range, huge deltas
      load_setup(16'hFFFF, 26'd65470464, 19'd1, 1'b1, TICK_MAX - 31'd1, TICK_MAX);
      queue_random(PHASE_ITEMS);

      // loop enabled but empty: saturation rules apply
      load_setup(16'd960, 26'd7864320, 19'd48000, 1'b1, 31'd5000, 31'd5000);
      queue_random(PHASE_ITEMS);

      // loop enabled but reversed
      load_setup(16'd96, 26'd8000000, 19'd96000, 1'b1, 31'd30000, 31'd100);
      queue_random(PHASE_ITEMS);

      // valid range with looping off: ignored
      load_setup(16'd960, 26'd7864320, 19'd48000, 1'b0, 31'd100, 31'd300000);
      queue_random(PHASE_ITEMS);

      // zero rate freezes the tick; zero ppq and sub-unit tempo clamp
      load_setup(16'd0, 26'd1234, 19'd0, 1'b1, 31'd10, 31'd2000);
      queue_random(PHASE_ITEMS / 2);
      load_setup(16'd0, 26'd0, 19'd7, 1'b1, 31'd10, 31'd2000);
      queue_random(PHASE_ITEMS);

      // random register sets
      repeat (4) begin
         rnd_start = 31'($urandom);
         load_setup(16'($urandom), 26'($urandom), 19'($urandom), 1'($urandom), rnd_start,
                    ($urandom_range(0, 1) != 0) ? 31'($urandom)
                                                : rnd_start + 31'($urandom_range(1, 100000)));
         queue_random(PHASE_ITEMS);
      end

      // widest loop at the highest rate
      load_setup(16'hFFFF, 26'd65470464, 19'd384000, 1'b1, 31'd0, TICK_MAX);
      queue_random(PHASE_ITEMS);

      // drain, then watch for stray results
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && tick_reports_due.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
